// File: rtl/visibility_phase_rotator_macros.svh
// Assertion helpers for the phase rotator, sampled on the block clock
`ifndef VISIBILITY_PHASE_ROTATOR_MACROS_SVH
`define VISIBILITY_PHASE_ROTATOR_MACROS_SVH

// Condition must imply consequence in the same cycle
`define VPR_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition must imply consequence in the following cycle
`define VPR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/vpr_pkg.sv
package vpr_pkg;

   // default configuration of the datapath
   localparam int NUM_CORR_DEF      = 4;
   localparam int SAMPLE_BITS_DEF   = 24;
   localparam int CORDIC_STAGES_DEF = 20;

   // fixed slot count of the transaction
   localparam int NUM_SLOTS = 4;

   // phase and phasor formats
   localparam int TURN_BITS = 32;   // phase, unsigned Q0.32 turn
   localparam int PROD_BITS = 36;   // low bits of rate * inverse wavelength
   localparam int TURN_LSB  = 4;    // Q16.16 * Q12.20 has 36 fraction bits
   localparam int XY_BITS   = 34;   // CORDIC x/y, Q2.30 with headroom
   localparam int Z_BITS    = 34;   // CORDIC residual angle
   localparam int CS_BITS   = 32;   // cos/sin, signed Q2.30
   localparam int CS_FRAC   = 30;

   // CORDIC start value, gain compensated (0.60725 in Q2.30)
   localparam logic [XY_BITS-1:0] CORDIC_GAIN = XY_BITS'(32'h26DD_3B6A);

   // arctan(2^-i) in units of 2^-32 turn
   localparam logic [TURN_BITS-1:0] ATAN_TURNS [32] = '{
      32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
      32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
      32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
      32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
      32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
      32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
      32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
      32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
   };

   // register file
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int NUM_POLS_W  = 3;
   localparam int CORR_MAP_W  = 8;
   localparam int MAP_FIELD_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_POLS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CORR_MAP = 2'd1;

   localparam logic [NUM_POLS_W-1:0] NUM_POLS_RST = 3'd4;
   localparam logic [CORR_MAP_W-1:0] CORR_MAP_RST = 8'd228;

endpackage

// File: rtl/visibility_phase_rotator.sv
// Visibility phase rotator. Takes one row/channel cell per transaction: four
// complex correlations, the row phase rate and the channel inverse
// wavelength. The phase (rate x inverse wavelength, fractional turns) drives
// a CORDIC with one register stage per iteration; each output slot p then
// takes the correlation chosen by corr_map[2p+1:2p], multiplies it by the
// conjugate phasor, rounds half up and saturates to SAMPLE_BITS. Slots at or
// above num_pols read as zero. One transaction is accepted every clock while
// req_stall is low; a result passes through the phase multiply, quadrant
// fold, CORDIC, phasor, product and rounding stages and then the output
// register. When the result side stalls, an output register and a one-entry
// skid buffer absorb the item in flight, after which req_stall rises and the
// whole pipeline holds. Configuration is written through the csr_ port while
// idle.
`include "visibility_phase_rotator_macros.svh"

module visibility_phase_rotator
   import vpr_pkg::*;
#(
   parameter int NUM_CORR      = NUM_CORR_DEF,
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_we,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_c0_re,
   input  logic signed [SAMPLE_BITS-1:0] req_c0_im,
   input  logic signed [SAMPLE_BITS-1:0] req_c1_re,
   input  logic signed [SAMPLE_BITS-1:0] req_c1_im,
   input  logic signed [SAMPLE_BITS-1:0] req_c2_re,
   input  logic signed [SAMPLE_BITS-1:0] req_c2_im,
   input  logic signed [SAMPLE_BITS-1:0] req_c3_re,
   input  logic signed [SAMPLE_BITS-1:0] req_c3_im,
   input  logic signed [TURN_BITS-1:0]   req_row_rate,
   input  logic [TURN_BITS-1:0]          req_inv_wavelength,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_o0_re,
   output logic signed [SAMPLE_BITS-1:0] rsp_o0_im,
   output logic signed [SAMPLE_BITS-1:0] rsp_o1_re,
   output logic signed [SAMPLE_BITS-1:0] rsp_o1_im,
   output logic signed [SAMPLE_BITS-1:0] rsp_o2_re,
   output logic signed [SAMPLE_BITS-1:0] rsp_o2_im,
   output logic signed [SAMPLE_BITS-1:0] rsp_o3_re,
   output logic signed [SAMPLE_BITS-1:0] rsp_o3_im
);

   // pipeline positions: 0 phase product, 1 fold, 2..ST+1 CORDIC,
   // ST+2 phasor, ST+3 products, ST+4 rounded result
   localparam int ST    = CORDIC_STAGES;
   localparam int NV    = ST + 5;
   localparam int NS    = ST + 3;
   localparam int PW    = SAMPLE_BITS + CS_BITS;
   localparam int SW    = PW + 1;
   localparam int SEL_W = MAP_FIELD_W + 1;

   localparam logic signed [SW-1:0] ROUND_HALF = SW'(1) <<< (CS_FRAC - 1);
   localparam logic signed [SW-1:0] SAT_MAX    = (SW'(1) <<< (SAMPLE_BITS - 1)) - SW'(1);
   localparam logic signed [SW-1:0] SAT_MIN    = -(SW'(1) <<< (SAMPLE_BITS - 1));

   // configuration registers
   logic [NUM_POLS_W-1:0] num_pols_ff;
   logic [CORR_MAP_W-1:0] corr_map_ff;

   // pipeline control
   logic          en;
   logic [NV-1:0] vld_ff, vld_in;

   // sample line
   logic signed [SAMPLE_BITS-1:0] in_re [NUM_SLOTS];
   logic signed [SAMPLE_BITS-1:0] in_im [NUM_SLOTS];
   logic signed [SAMPLE_BITS-1:0] sel_re [NUM_SLOTS];
   logic signed [SAMPLE_BITS-1:0] sel_im [NUM_SLOTS];
   logic signed [SAMPLE_BITS-1:0] smp_re_ff [NS][NUM_SLOTS];
   logic signed [SAMPLE_BITS-1:0] smp_im_ff [NS][NUM_SLOTS];

   // phase and CORDIC
   logic [PROD_BITS-1:0]         phase_prod;
   logic [TURN_BITS-1:0]         turns_ff;
   logic                         fold;
   logic [TURN_BITS-1:0]         turns_fold;
   logic signed [XY_BITS-1:0]    x_ff [0:ST];
   logic signed [XY_BITS-1:0]    y_ff [0:ST];
   logic signed [Z_BITS-1:0]     z_ff [0:ST];
   logic                         flip_ff [1:ST+1];
   logic signed [CS_BITS-1:0]    cos_ff, sin_ff, cos_in, sin_in;

   // products and results
   logic signed [PW-1:0] prd_rc_ff [NUM_SLOTS];
   logic signed [PW-1:0] prd_is_ff [NUM_SLOTS];
   logic signed [PW-1:0] prd_ic_ff [NUM_SLOTS];
   logic signed [PW-1:0] prd_rs_ff [NUM_SLOTS];
   logic signed [SAMPLE_BITS-1:0] res_re_ff [NUM_SLOTS];
   logic signed [SAMPLE_BITS-1:0] res_im_ff [NUM_SLOTS];
   logic signed [SAMPLE_BITS-1:0] res_re_in [NUM_SLOTS];
   logic signed [SAMPLE_BITS-1:0] res_im_in [NUM_SLOTS];

   // output register and skid buffer
   logic                          rsp_valid_ff;
   logic                          skid_vld_ff;
   logic                          out_free;
   logic signed [SAMPLE_BITS-1:0] out_re_ff [NUM_SLOTS];
   logic signed [SAMPLE_BITS-1:0] out_im_ff [NUM_SLOTS];
   logic signed [SAMPLE_BITS-1:0] skd_re_ff [NUM_SLOTS];
   logic signed [SAMPLE_BITS-1:0] skd_im_ff [NUM_SLOTS];

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         num_pols_ff <= NUM_POLS_RST;
         corr_map_ff <= CORR_MAP_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NUM_POLS: begin
               num_pols_ff <= csr_wdata[NUM_POLS_W-1:0];
            end
            CSR_CORR_MAP: begin
               corr_map_ff <= csr_wdata[CORR_MAP_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // whole pipeline holds while the skid buffer is occupied
   assign en        = !skid_vld_ff;
   assign req_stall = skid_vld_ff;
   assign vld_in    = {vld_ff[NV-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // slot selection; unused slots and missing inputs become zero
   assign in_re[0] = req_c0_re;
   assign in_im[0] = req_c0_im;
   assign in_re[1] = req_c1_re;
   assign in_im[1] = req_c1_im;
   assign in_re[2] = req_c2_re;
   assign in_im[2] = req_c2_im;
   assign in_re[3] = req_c3_re;
   assign in_im[3] = req_c3_im;

   always_comb begin
      logic [MAP_FIELD_W-1:0] m;
      logic                   use_slot;
      m        = '0;
      use_slot = 1'b0;
      for (int p = 0; p < NUM_SLOTS; p++) begin
         m        = corr_map_ff[MAP_FIELD_W*p +: MAP_FIELD_W];
         use_slot = (NUM_POLS_W'(p) < num_pols_ff) && ({1'b0, m} < SEL_W'(NUM_CORR));
         sel_re[p] = use_slot ? in_re[m] : '0;
         sel_im[p] = use_slot ? in_im[m] : '0;
      end
   end

   // samples travel alongside the phasor
   always_ff @(posedge clock) begin
      if (en) begin
         smp_re_ff[0] <= sel_re;
         smp_im_ff[0] <= sel_im;
         for (int j = 1; j < NS; j++) begin
            smp_re_ff[j] <= smp_re_ff[j-1];
            smp_im_ff[j] <= smp_im_ff[j-1];
         end
      end
   end

   // phase in turns: only the low product bits matter, rate sign-extended
   assign phase_prod = {{(PROD_BITS-TURN_BITS){req_row_rate[TURN_BITS-1]}}, req_row_rate}
                       * PROD_BITS'(req_inv_wavelength);

   always_ff @(posedge clock) begin
      if (en) begin
         turns_ff <= phase_prod[TURN_LSB +: TURN_BITS];
      end
   end

   // fold the left half plane by half a turn, negate the phasor later
   assign fold       = (turns_ff[TURN_BITS-1] != turns_ff[TURN_BITS-2]);
   assign turns_fold = {turns_ff[TURN_BITS-1] ^ fold, turns_ff[TURN_BITS-2:0]};

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= CORDIC_GAIN;
         y_ff[0]    <= '0;
         z_ff[0]    <= Z_BITS'($signed(turns_fold));
         flip_ff[1] <= fold;
      end
   end

   // CORDIC, one rotation per register stage
   for (genvar k = 0; k < ST; k++) begin : g_cordic
      localparam logic signed [Z_BITS-1:0] ANG = Z_BITS'(ATAN_TURNS[k]);
      logic signed [XY_BITS-1:0] x_in, y_in, dx, dy;
      logic signed [Z_BITS-1:0]  z_in;

      always_comb begin
         dx = y_ff[k] >>> k;
         dy = x_ff[k] >>> k;
         if (!z_ff[k][Z_BITS-1]) begin
            x_in = x_ff[k] - dx;
            y_in = y_ff[k] + dy;
            z_in = z_ff[k] - ANG;
         end else begin
            x_in = x_ff[k] + dx;
            y_in = y_ff[k] - dy;
            z_in = z_ff[k] + ANG;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k+1]    <= x_in;
            y_ff[k+1]    <= y_in;
            z_ff[k+1]    <= z_in;
            flip_ff[k+2] <= flip_ff[k+1];
         end
      end
   end

   // phasor with the fold undone
   assign cos_in = CS_BITS'(flip_ff[ST+1] ? -x_ff[ST] : x_ff[ST]);
   assign sin_in = CS_BITS'(flip_ff[ST+1] ? -y_ff[ST] : y_ff[ST]);

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   // four partial products per slot
   always_ff @(posedge clock) begin
      if (en) begin
         for (int p = 0; p < NUM_SLOTS; p++) begin
            prd_rc_ff[p] <= PW'(smp_re_ff[NS-1][p]) * PW'(cos_ff);
            prd_is_ff[p] <= PW'(smp_im_ff[NS-1][p]) * PW'(sin_ff);
            prd_ic_ff[p] <= PW'(smp_im_ff[NS-1][p]) * PW'(cos_ff);
            prd_rs_ff[p] <= PW'(smp_re_ff[NS-1][p]) * PW'(sin_ff);
         end
      end
   end

   // combine, round half up, saturate
   always_comb begin
      logic signed [SW-1:0] sum_re, sum_im;
      sum_re = '0;
      sum_im = '0;
      for (int p = 0; p < NUM_SLOTS; p++) begin
         sum_re = (SW'(prd_rc_ff[p]) + SW'(prd_is_ff[p]) + ROUND_HALF) >>> CS_FRAC;
         sum_im = (SW'(prd_ic_ff[p]) - SW'(prd_rs_ff[p]) + ROUND_HALF) >>> CS_FRAC;
         if (sum_re > SAT_MAX) begin
            res_re_in[p] = SAMPLE_BITS'(SAT_MAX);
         end else if (sum_re < SAT_MIN) begin
            res_re_in[p] = SAMPLE_BITS'(SAT_MIN);
         end else begin
            res_re_in[p] = SAMPLE_BITS'(sum_re);
         end
         if (sum_im > SAT_MAX) begin
            res_im_in[p] = SAMPLE_BITS'(SAT_MAX);
         end else if (sum_im < SAT_MIN) begin
            res_im_in[p] = SAMPLE_BITS'(SAT_MIN);
         end else begin
            res_im_in[p] = SAMPLE_BITS'(sum_im);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
      end
   end

   // output register with one-entry skid buffer
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_vld_ff  <= 1'b0;
      end else if (skid_vld_ff) begin
         if (out_free) begin
            rsp_valid_ff <= 1'b1;
            skid_vld_ff  <= 1'b0;
         end
      end else if (out_free) begin
         rsp_valid_ff <= vld_ff[NV-1];
      end else if (vld_ff[NV-1]) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (out_free) begin
            out_re_ff <= skd_re_ff;
            out_im_ff <= skd_im_ff;
         end
      end else if (out_free) begin
         out_re_ff <= res_re_ff;
         out_im_ff <= res_im_ff;
      end else begin
         skd_re_ff <= res_re_ff;
         skd_im_ff <= res_im_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_o0_re = out_re_ff[0];
   assign rsp_o0_im = out_im_ff[0];
   assign rsp_o1_re = out_re_ff[1];
   assign rsp_o1_im = out_im_ff[1];
   assign rsp_o2_re = out_re_ff[2];
   assign rsp_o2_im = out_im_ff[2];
   assign rsp_o3_re = out_re_ff[3];
   assign rsp_o3_im = out_im_ff[3];

   // checks
   `VPR_ASSERT_IMPLY(a_skid_needs_out, skid_vld_ff, rsp_valid_ff, "skid holds data with output empty")
   `VPR_ASSERT_NEXT(a_skid_freezes, skid_vld_ff && !out_free, $stable(vld_ff), "pipeline moved while skid full")
   `VPR_ASSERT_NEXT(a_skid_fill, !skid_vld_ff && vld_ff[NV-1] && !out_free, skid_vld_ff, "stalled result not caught by skid")

endmodule
